// ----- src/tti_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tti_pkg;

  localparam int RAW_W     = 16;
  localparam int TEMP_W    = 16;
  localparam int SAMPLE_W  = 15;
  localparam int Q_W       = 24;
  localparam int CFG_W     = 7;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;
  localparam int NUM_W     = 40;
  localparam int DEN_W     = 17;
  localparam int DIV_CNT_W = 6;
  localparam int Q_MAX     = 8388607;
  localparam int Q_MIN     = -8388608;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  localparam logic REG_ENTRIES_CH0 = 1'b0;
  localparam logic REG_ENTRIES_CH1 = 1'b1;

  typedef struct packed {
    logic                     command;
    logic                     channel;
    logic [5:0]               entry_index;
    logic signed [RAW_W-1:0]  entry_raw;
    logic signed [TEMP_W-1:0] entry_temp;
    logic [SAMPLE_W-1:0]      sample_raw;
  } tti_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] celsius_q8;
    logic                  above_table;
  } tti_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_SUM,
    ST_OUT
  } tti_state_t;

endpackage

`default_nettype wire

// ----- src/tti_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire              clk,
  input  wire              we,
  input  wire [AW-1:0]     addr,
  input  wire [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- src/thermistor_table_interpolator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports                               Transaction
// in       in_valid/in_ready, in_data          write one table pair, or convert a reading
// out      out_valid/out_ready, out_data       one Q8 temperature per convert
// cfg      psel/penable/pwrite/paddr/pwdata    table entry counts per channel
//
// Writes are accepted only in idle. A convert reads one table entry per cycle, then a
// restoring divider retires one quotient bit per cycle over the 40 numerator bits;
// equal raw points skip the divider, and a reading above the table goes straight to
// the output step. No new transaction is accepted while a convert runs.
// A waiting result does not block input; the next convert holds in its output step.
// Tables are not cleared at reset and stay undefined until written.

module thermistor_table_interpolator #(
  parameter int MAX_ENTRIES = 64,
  parameter int CHANNELS    = 2
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire tti_pkg::tti_in_t             in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output tti_pkg::tti_out_t                 out_data,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [tti_pkg::PADDR_W-1:0]        paddr,
  input  wire [tti_pkg::DATA_W-1:0]         pwdata,
  output logic [tti_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  import tti_pkg::*;

  localparam int DEPTH  = CHANNELS * MAX_ENTRIES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int PROD_W = 35;
  localparam int SUM_W  = NUM_W + 2;

  tti_state_t state_r, state_nxt;

  logic [CFG_W-1:0] ent0_r, ent1_r, cnt_sel;
  logic             cfg_sel, cfg_we;

  logic                 ch_r;
  logic [SAMPLE_W-1:0]  sample_r;
  logic [IDX_W-1:0]     last_idx_r, last_nxt;
  logic [IDX_W-1:0]     rd_idx_r, chk_idx_r;
  logic                 chk_vld_r;
  logic signed [15:0]   prev_raw_r, prev_temp_r, t0_r;
  logic signed [17:0]   diff_r;
  logic signed [16:0]   dt_r, den_r;
  logic signed [PROD_W-1:0] prod_r, prod_mag;
  logic [NUM_W-1:0]     num_r;
  logic [DEN_W-1:0]     rem_r, den_mag_r, den_mag;
  logic [DEN_W:0]       rem_sh, rem_sub;
  logic                 rem_ge;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic signed [Q_W-1:0] res_r;
  logic                 above_r;
  logic signed [SUM_W-1:0] q_s, sum_s;
  logic signed [Q_W-1:0] sat_s;

  logic                 out_valid_r;
  tti_out_t             out_data_r;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr, wr_addr, rd_addr;
  logic [31:0]          ram_rdata;
  logic signed [15:0]   rd_raw, rd_temp;
  logic                 ch_ok, pos_ok, exceed, out_free;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_sel = paddr[PADDR_W-1];
  assign cfg_we  = psel & penable & pwrite;
  assign prdata  = (cfg_sel == REG_ENTRIES_CH1) ? {{(DATA_W-CFG_W){1'b0}}, ent1_r}
                                                : {{(DATA_W-CFG_W){1'b0}}, ent0_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent0_r <= CFG_W'(2);
      ent1_r <= CFG_W'(2);
    end else if (cfg_we) begin
      case (cfg_sel)
        REG_ENTRIES_CH0: ent0_r <= pwdata[CFG_W-1:0];
        REG_ENTRIES_CH1: ent1_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode of the incoming transaction
  assign ch_ok   = int'(in_data.channel) < CHANNELS;
  assign pos_ok  = int'(in_data.entry_index) < MAX_ENTRIES;
  assign wr_addr = ADDR_W'(int'(in_data.channel) * MAX_ENTRIES + int'(in_data.entry_index));
  assign rd_addr = ADDR_W'(int'(ch_r) * MAX_ENTRIES + int'(rd_idx_r));
  assign cnt_sel = in_data.channel ? ent1_r : ent0_r;

  always_comb begin
    if (cnt_sel < CFG_W'(2)) begin
      last_nxt = IDX_W'(1);
    end else if (int'(cnt_sel) > MAX_ENTRIES) begin
      last_nxt = IDX_W'(MAX_ENTRIES - 1);
    end else begin
      last_nxt = IDX_W'(cnt_sel - CFG_W'(1));
    end
  end

  tti_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({in_data.entry_raw, in_data.entry_temp}),
    .rdata (ram_rdata)
  );

  assign rd_raw  = ram_rdata[31:16];
  assign rd_temp = ram_rdata[15:0];
  assign exceed  = $signed({rd_raw[15], rd_raw}) > $signed({2'b00, sample_r});
  assign out_free = !out_valid_r || out_ready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = rd_addr;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.command == CMD_WRITE) begin
            if (ch_ok && pos_ok) begin
              ram_we   = 1'b1;
              ram_addr = wr_addr;
            end
          end else if (ch_ok) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (chk_vld_r && chk_idx_r != '0) begin
          if (exceed) begin
            state_nxt = ST_MUL;
          end else if (chk_idx_r == last_idx_r) begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_MUL:  state_nxt = ST_PREP;
      ST_PREP: state_nxt = (den_r == '0) ? ST_SUM : ST_DIV;
      ST_DIV: begin
        if (div_cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath
  assign prod_mag = prod_r[PROD_W-1] ? -prod_r : prod_r;
  assign den_mag  = den_r[16] ? DEN_W'(-den_r) : DEN_W'(den_r);
  assign rem_sh   = {rem_r, num_r[NUM_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, den_mag_r};
  assign rem_sub  = rem_ge ? (rem_sh - {1'b0, den_mag_r}) : rem_sh;
  assign q_s      = neg_r ? -$signed({2'b00, num_r}) : $signed({2'b00, num_r});
  assign sum_s    = $signed({{(SUM_W-Q_W){t0_r[15]}}, t0_r, 8'h00}) + q_s;

  always_comb begin
    if (sum_s > SUM_W'(Q_MAX)) begin
      sat_s = Q_W'(Q_MAX);
    end else if (sum_s < SUM_W'(Q_MIN)) begin
      sat_s = Q_W'(Q_MIN);
    end else begin
      sat_s = sum_s[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_data.command == CMD_CONVERT) begin
          ch_r       <= in_data.channel;
          sample_r   <= in_data.sample_raw;
          last_idx_r <= last_nxt;
          rd_idx_r   <= '0;
          chk_vld_r  <= 1'b0;
        end
      end
      ST_SCAN: begin
        chk_vld_r <= 1'b1;
        chk_idx_r <= rd_idx_r;
        if (rd_idx_r != last_idx_r) begin
          rd_idx_r <= rd_idx_r + IDX_W'(1);
        end
        if (chk_vld_r) begin
          prev_raw_r  <= rd_raw;
          prev_temp_r <= rd_temp;
          diff_r      <= $signed({3'b000, sample_r}) - $signed({{2{prev_raw_r[15]}}, prev_raw_r});
          dt_r        <= $signed({rd_temp[15], rd_temp}) - $signed({prev_temp_r[15], prev_temp_r});
          den_r       <= $signed({rd_raw[15], rd_raw}) - $signed({prev_raw_r[15], prev_raw_r});
          t0_r        <= prev_temp_r;
          res_r       <= {rd_temp, 8'h00};
          above_r     <= 1'b1;
        end
      end
      ST_MUL: begin
        prod_r  <= diff_r * dt_r;
        above_r <= 1'b0;
      end
      ST_PREP: begin
        num_r     <= (den_r == '0) ? '0 : {prod_mag[31:0], 8'h00};
        den_mag_r <= den_mag;
        neg_r     <= prod_r[PROD_W-1] ^ den_r[16];
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r     <= rem_sub[DEN_W-1:0];
        num_r     <= {num_r[NUM_W-2:0], rem_ge};
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      ST_SUM: begin
        res_r <= sat_s;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_data_r.celsius_q8  <= res_r;
      out_data_r.above_table <= above_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_IDLE)
    else $error("table write outside idle");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> rd_idx_r <= last_idx_r)
    else $error("scan read past last entry");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> div_cnt_r < DIV_CNT_W'(NUM_W))
    else $error("divider ran too long");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_OUT))
    else $error("result without a finished convert");

  a_convert_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command == CMD_CONVERT &&
     int'(in_data.channel) < CHANNELS) |=> state_r == ST_SCAN)
    else $error("convert transaction did not start a scan");

endmodule

`default_nettype wire
